// ===== rtl/mfq_pkg.sv =====
// Shared types and constants of the multilevel feedback task picker.
// Used by the channel interfaces, the slot cell and the top level; depends on nothing.
package mfq_pkg;

  localparam int unsigned DefSlots   = 16;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned SlotFieldW = 4;

  localparam logic [TimeW-1:0] TimeMax = '1;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam logic [LevelW-1:0] LevelTop = 2'd0;
  localparam logic [LevelW-1:0] LevelMid = 2'd1;
  localparam logic [LevelW-1:0] LevelLow = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_e;

  // Best candidate of one level seen so far along the chain.
  typedef struct packed {
    logic             found;
    logic [TimeW-1:0] key;
    logic [TimeW-1:0] arrive;
    logic [TimeW-1:0] rem;
  } cand_t;

  // What the chain learned about the running task of one level.
  typedef struct packed {
    logic             hit;
    logic [TimeW-1:0] key;
    logic [TimeW-1:0] rem;
  } run_t;

  typedef struct packed {
    cand_t best;
    run_t  run;
  } tok_t;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic              load;
    logic              serve;
    logic              demote;
    logic [LevelW-1:0] dem_level;
    logic [TimeW-1:0]  burst;
    logic [TimeW-1:0]  arrive;
    logic [PrioW-1:0]  prio;
    logic [LevelW-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic                  served;
    logic [SlotFieldW-1:0] served_slot;
    logic                  served_level;
    logic                  finished;
    logic [TimeW-1:0]      finish_time;
    logic [TimeW-1:0]      now;
  } rsp_t;

endpackage

// ===== rtl/mfq_req_if.sv =====
// Request channel of the task picker: load and tick beats.
// Depends on mfq_pkg for the field widths.
interface mfq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [mfq_pkg::SlotFieldW-1:0]    slot;
  logic [mfq_pkg::TimeW-1:0]         burst;
  logic [mfq_pkg::TimeW-1:0]         arrival;
  logic [mfq_pkg::PrioW-1:0]         prio;
  logic [mfq_pkg::LevelW-1:0]        start_level;

  modport source (
    output valid, func, slot, burst, arrival, prio, start_level,
    input  ready
  );
  modport sink (
    input  valid, func, slot, burst, arrival, prio, start_level,
    output ready
  );
endinterface

// ===== rtl/mfq_rsp_if.sv =====
// Response channel of the task picker: one beat per request beat.
// Depends on mfq_pkg for the field widths.
interface mfq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           served;
  logic [mfq_pkg::SlotFieldW-1:0] served_slot;
  logic                           served_level;
  logic                           finished;
  logic [mfq_pkg::TimeW-1:0]      finish_time;
  logic [mfq_pkg::TimeW-1:0]      now;

  modport source (
    output valid, served, served_slot, served_level, finished, finish_time, now,
    input  ready
  );
  modport sink (
    input  valid, served, served_slot, served_level, finished, finish_time, now,
    output ready
  );
endinterface

// ===== rtl/mfq_cell.sv =====
// One task slot of the picker: holds the slot's task and compares it against
// the candidates handed in by its left neighbor. Depends on mfq_pkg.
module mfq_cell #(
  parameter int unsigned SLOTS = mfq_pkg::DefSlots,
  parameter int unsigned IDX   = 0,
  localparam int unsigned SW   = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mfq_pkg::TimeW-1:0]    now_i,
  input  mfq_pkg::cmd_t                cmd_i,
  input  logic                         ld_sel_i,
  input  logic [SW-1:0]                serve_slot_i,
  input  logic [SW-1:0]                dem_slot_i,
  input  logic [1:0]                   run_valid_i,
  input  logic [1:0][SW-1:0]           run_slot_i,
  input  mfq_pkg::tok_t [1:0]          tok_i,
  input  logic [1:0][SW-1:0]           tok_slot_i,
  output mfq_pkg::tok_t [1:0]          tok_o,
  output logic [1:0][SW-1:0]           tok_slot_o
);

  localparam logic [SW-1:0] Self = SW'(IDX);

  logic                            used_q;
  logic                            done_q;
  logic [mfq_pkg::TimeW-1:0]       rem_q;
  logic [mfq_pkg::TimeW-1:0]       arr_q;
  logic [mfq_pkg::PrioW-1:0]       prio_q;
  logic [mfq_pkg::LevelW-1:0]      level_q;

  mfq_pkg::tok_t [1:0]             tok_d;
  logic [1:0][SW-1:0]              tok_slot_d;
  mfq_pkg::tok_t [1:0]             tok_q;
  logic [1:0][SW-1:0]              tok_slot_q;

  logic                            load_hit;
  logic                            serve_hit;
  logic                            dem_hit;
  logic                            rem_last;

  assign load_hit  = cmd_i.load && ld_sel_i;
  assign serve_hit = cmd_i.serve && (serve_slot_i == Self);
  assign dem_hit   = cmd_i.demote && (dem_slot_i == Self) && !done_q;
  assign rem_last  = (rem_q <= mfq_pkg::TimeW'(1));

  // Candidate compare for both levels; lower slots sit further left, so a
  // full tie keeps the candidate that is already in the token.
  always_comb begin
    logic                      base_rdy;
    logic                      rdy;
    logic [mfq_pkg::TimeW-1:0] key;
    logic                      better;
    base_rdy = used_q && !done_q && (arr_q <= now_i);
    for (int l = 0; l < 2; l++) begin
      rdy    = base_rdy && (level_q == mfq_pkg::LevelW'(l));
      key    = (l == 0) ? rem_q : mfq_pkg::TimeW'(prio_q);
      better = !tok_i[l].best.found || (key < tok_i[l].best.key) ||
               ((key == tok_i[l].best.key) && (arr_q < tok_i[l].best.arrive));
      tok_d[l]      = tok_i[l];
      tok_slot_d[l] = tok_slot_i[l];
      if (rdy && better) begin
        tok_d[l].best = '{found: 1'b1, key: key, arrive: arr_q, rem: rem_q};
        tok_slot_d[l] = Self;
      end
      if (rdy && run_valid_i[l] && (run_slot_i[l] == Self)) begin
        tok_d[l].run = '{hit: 1'b1, key: key, rem: rem_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= 1'b0;
      done_q     <= 1'b0;
      tok_q      <= '0;
      tok_slot_q <= '0;
    end else begin
      tok_q      <= tok_d;
      tok_slot_q <= tok_slot_d;
      if (load_hit) begin
        used_q <= 1'b1;
        done_q <= 1'b0;
      end else if (serve_hit && rem_last) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      rem_q   <= cmd_i.burst;
      arr_q   <= cmd_i.arrive;
      prio_q  <= cmd_i.prio;
      level_q <= cmd_i.level;
    end else begin
      if (serve_hit) begin
        rem_q <= rem_last ? '0 : rem_q - mfq_pkg::TimeW'(1);
      end
      if (dem_hit) begin
        level_q <= cmd_i.dem_level;
      end
    end
  end

  assign tok_o      = tok_q;
  assign tok_slot_o = tok_slot_q;

endmodule

// ===== rtl/multilevel_feedback_task_picker.sv =====
// Top level of the multilevel feedback task picker: control, time counter,
// running-task flags and the chain of slot cells. Depends on mfq_pkg,
// mfq_req_if, mfq_rsp_if and mfq_cell.
//
//   Channel   Role     Beat carries
//   -------   ------   ---------------------------------------------------------
//   req_i     sink     func, slot, burst, arrival, prio, start_level
//   rsp_o     source   served, served_slot, served_level, finished, finish_time, now
//
// A load beat passes through the emit state and then returns to idle.
// A tick beat walks down the chain in the sweep state, picks and updates at
// its end, fills the output register in emit and returns to idle.
// Reset is asynchronous and clears the time, the running flags and the used and
// done marks of every cell. A result waits in the output register while the next
// beat is accepted; one that finds that register still full waits in emit.
module multilevel_feedback_task_picker #(
  parameter int unsigned SLOTS = mfq_pkg::DefSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfq_req_if.sink     req_i,
  mfq_rsp_if.source   rsp_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  mfq_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [mfq_pkg::TimeW-1:0]  tick_q, tick_d;
  logic [1:0]                 run_v_q, run_v_d;
  logic [1:0][SW-1:0]         run_s_q, run_s_d;
  mfq_pkg::rsp_t              res_q, res_d;
  mfq_pkg::rsp_t              out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       in_fire;
  logic                       decide;
  mfq_pkg::cmd_t              cmd;
  logic [SLOTS-1:0]           ld_sel;
  logic [SW-1:0]              pick_s;
  logic                       lvl_sel;
  logic                       served;
  logic                       fin;
  mfq_pkg::rsp_t              tick_res;

  // Chain wiring: entry 0 is the empty token, entry SLOTS the tail.
  mfq_pkg::tok_t [1:0]        tok_w  [SLOTS+1];
  logic [1:0][SW-1:0]         slot_w [SLOTS+1];

  assign tok_w[0]  = '0;
  assign slot_w[0] = '0;

  assign in_fire = req_i.valid && req_i.ready;
  assign decide  = (state_q == mfq_pkg::ST_SWEEP) && (cnt_q == CW'(SLOTS));

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    // Slots past the 4-bit field are never selected by a load.
    assign ld_sel[i] = (int'(req_i.slot) == int'(i));

    mfq_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .now_i        (tick_q),
      .cmd_i        (cmd),
      .ld_sel_i     (ld_sel[i]),
      .serve_slot_i (pick_s),
      .dem_slot_i   (run_s_q[lvl_sel]),
      .run_valid_i  (run_v_q),
      .run_slot_i   (run_s_q),
      .tok_i        (tok_w[i]),
      .tok_slot_i   (slot_w[i]),
      .tok_o        (tok_w[i+1]),
      .tok_slot_o   (slot_w[i+1])
    );
  end

  // Pick from the tail of the chain. The running task of a level wins when
  // it is ready there and ties the best on the primary key. Level 0 goes
  // first; level 1 is served only when nothing is ready at level 0.
  always_comb begin
    logic [1:0][SW-1:0]                 lvl_s;
    logic [1:0][mfq_pkg::TimeW-1:0]     lvl_rem;
    logic [mfq_pkg::TimeW-1:0]          rem;
    logic [mfq_pkg::TimeW-1:0]          ft;
    for (int l = 0; l < 2; l++) begin
      if (tok_w[SLOTS][l].run.hit &&
          (tok_w[SLOTS][l].run.key == tok_w[SLOTS][l].best.key)) begin
        lvl_s[l]   = run_s_q[l];
        lvl_rem[l] = tok_w[SLOTS][l].run.rem;
      end else begin
        lvl_s[l]   = slot_w[SLOTS][l];
        lvl_rem[l] = tok_w[SLOTS][l].best.rem;
      end
    end
    lvl_sel = !tok_w[SLOTS][0].best.found;
    served  = tok_w[SLOTS][0].best.found || tok_w[SLOTS][1].best.found;
    pick_s  = lvl_s[lvl_sel];
    rem     = lvl_rem[lvl_sel];
    fin     = served && (rem <= mfq_pkg::TimeW'(1));
    ft      = (tick_q == mfq_pkg::TimeMax) ? mfq_pkg::TimeMax
                                           : tick_q + mfq_pkg::TimeW'(1);

    tick_res              = '0;
    tick_res.now          = tick_q;
    tick_res.served       = served;
    tick_res.served_slot  = served ? mfq_pkg::SlotFieldW'(pick_s) : '0;
    tick_res.served_level = served && lvl_sel;
    tick_res.finished     = fin;
    tick_res.finish_time  = fin ? ft : '0;
  end

  // Command to the cells. A start level of three is stored as level 2.
  always_comb begin
    cmd           = '0;
    cmd.load      = in_fire && (req_i.func == mfq_pkg::FuncLoad);
    cmd.serve     = decide && served;
    cmd.demote    = decide && served && run_v_q[lvl_sel] && (run_s_q[lvl_sel] != pick_s);
    cmd.dem_level = mfq_pkg::LevelW'(lvl_sel) + mfq_pkg::LevelW'(1);
    cmd.burst     = req_i.burst;
    cmd.arrive    = req_i.arrival;
    cmd.prio      = req_i.prio;
    cmd.level     = (req_i.start_level > mfq_pkg::LevelLow) ? mfq_pkg::LevelLow
                                                            : req_i.start_level;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    run_v_d     = run_v_q;
    run_s_d     = run_s_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mfq_pkg::ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          if (req_i.func == mfq_pkg::FuncLoad) begin
            res_d     = '0;
            res_d.now = tick_q;
            // A reloaded slot is no longer anyone's running task.
            for (int l = 0; l < 2; l++) begin
              if (run_v_q[l] && (int'(run_s_q[l]) == int'(req_i.slot))) begin
                run_v_d[l] = 1'b0;
              end
            end
            state_d = mfq_pkg::ST_EMIT;
          end else begin
            state_d = mfq_pkg::ST_SWEEP;
          end
        end
      end
      mfq_pkg::ST_SWEEP: begin
        cnt_d = cnt_q + CW'(1);
        if (decide) begin
          res_d = tick_res;
          if (served) begin
            run_v_d[lvl_sel] = 1'b1;
            run_s_d[lvl_sel] = pick_s;
          end
          if (tick_q != mfq_pkg::TimeMax) begin
            tick_d = tick_q + mfq_pkg::TimeW'(1);
          end
          state_d = mfq_pkg::ST_EMIT;
        end
      end
      mfq_pkg::ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = mfq_pkg::ST_IDLE;
        end
      end
      default: state_d = mfq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfq_pkg::ST_IDLE;
      cnt_q       <= '0;
      tick_q      <= '0;
      run_v_q     <= '0;
      run_s_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      run_v_q     <= run_v_d;
      run_s_q     <= run_s_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign req_i.ready        = (state_q == mfq_pkg::ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.served       = out_q.served;
  assign rsp_o.served_slot  = out_q.served_slot;
  assign rsp_o.served_level = out_q.served_level;
  assign rsp_o.finished     = out_q.finished;
  assign rsp_o.finish_time  = out_q.finish_time;
  assign rsp_o.now          = out_q.now;

`ifndef SYNTH
  // The tick count moves only on the cycle that picks a task.
  a_tick_only_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q != $past(tick_q)) |-> $past(decide))
    else $error("tick count changed outside the pick cycle");

  // After a pick the result is waiting for the output register.
  a_decide_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide |=> (state_q == mfq_pkg::ST_EMIT))
    else $error("pick cycle not followed by emit");

  // A running flag always points at a slot that exists.
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_v_q[0] |-> (int'(run_s_q[0]) < SLOTS)) and
    (run_v_q[1] |-> (int'(run_s_q[1]) < SLOTS)))
    else $error("running flag points beyond the slot table");

  // A finished beat always reports a served task.
  a_finish_needs_serve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.finished || rsp_o.served))
    else $error("finished beat without a served task");
`endif

endmodule
